>>> hw/rtl/pcmf_pkg.sv
`timescale 1ns / 1ps
package pcmf_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_S64 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5
  } fmt_t;

  // conversion path chosen in stage 1
  typedef enum logic [1:0] {
    PATH_INT  = 2'd0,
    PATH_PASS = 2'd1,
    PATH_F64  = 2'd2,
    PATH_ZERO = 2'd3
  } path_t;

  localparam logic [31:0] F32_INF   = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;

endpackage

>>> hw/rtl/pcmf_stream_if.sv
`timescale 1ns / 1ps
interface pcmf_stream_if #(
  parameter int W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pcm_sample_to_float32.sv
`timescale 1ns / 1ps
// PCM sample to float32 converter. One sample enters per clock unless the output stalls;
// its float32 bit pattern leaves through a four-stage pipeline (decode and magnitude,
// leading-one search, normalizing shift, rounding and packing); every stage advances
// whenever the stage after it is empty or is emptying, so the output may stall without
// losing a transaction. The user must write the format register (0 u8, 1 s16, 2 s32, 3 s64,
// 4 float32, 5 float64) via cfg only while the pipeline is empty; the block does not check.
module pcm_sample_to_float32 (
  input  logic           clk,
  input  logic           rst_n,
  pcmf_stream_if.sink    in_if,
  pcmf_stream_if.source  out_if,
  pcmf_stream_if.sink    cfg_if
);
  import pcmf_pkg::*;

  logic [2:0] fmt_r;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 3'd0;
    end else if (cfg_if.valid) begin
      fmt_r <= cfg_if.data[2:0];
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;
  assign adv4 = !v4_r || out_if.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_if.ready = adv1;

  // ---------- stage 1: decode ----------
  logic [63:0] raw;
  path_t       path_nxt;
  logic        sign_nxt;
  logic [63:0] mag_nxt;
  logic [6:0]  scale_nxt;
  logic [31:0] word_nxt;
  logic [10:0] de;
  logic [51:0] df;
  logic [11:0] deb;

  assign raw = in_if.data;
  assign de  = raw[62:52];
  assign df  = raw[51:0];
  assign deb = 12'({1'b0, de}) - 12'd896;

  always_comb begin
    path_nxt  = PATH_ZERO;
    sign_nxt  = 1'b0;
    mag_nxt   = 64'd0;
    scale_nxt = 7'd0;
    word_nxt  = 32'd0;
    case (fmt_r)
      FMT_U8: begin
        path_nxt  = PATH_INT;
        sign_nxt  = !raw[7];
        mag_nxt   = raw[7] ? 64'({1'b0, raw[6:0]}) : 64'(9'd128 - 9'({1'b0, raw[7:0]}));
        scale_nxt = 7'd7;
      end
      FMT_S16: begin
        path_nxt  = PATH_INT;
        sign_nxt  = raw[15];
        mag_nxt   = raw[15] ? 64'(17'h10000 - 17'({1'b0, raw[15:0]})) : 64'(raw[15:0]);
        scale_nxt = 7'd15;
      end
      FMT_S32: begin
        path_nxt  = PATH_INT;
        sign_nxt  = raw[31];
        mag_nxt   = raw[31] ? 64'(33'h1_0000_0000 - 33'({1'b0, raw[31:0]}))
                            : 64'(raw[31:0]);
        scale_nxt = 7'd31;
      end
      FMT_S64: begin
        path_nxt  = PATH_INT;
        sign_nxt  = raw[63];
        mag_nxt   = raw[63] ? (~raw) + 64'd1 : raw;
        scale_nxt = 7'd63;
      end
      FMT_F32: begin
        path_nxt = PATH_PASS;
        word_nxt = raw[31:0];
      end
      FMT_F64: begin
        sign_nxt = raw[63];
        if (de == 11'h7FF) begin
          path_nxt = PATH_PASS;
          word_nxt = (df == 52'd0) ? ({raw[63], 31'd0} | F32_INF)
                                   : ({raw[63], 31'd0} | F32_QNAN | 32'(df[51:29]));
        end else if (de == 11'd0) begin
          path_nxt = PATH_PASS;
          word_nxt = {raw[63], 31'd0};
        end else if (!deb[11] && deb >= 12'd255) begin
          path_nxt = PATH_PASS;
          word_nxt = {raw[63], 31'd0} | F32_INF;
        end else begin
          path_nxt = PATH_F64;
          mag_nxt  = {11'd0, 1'b1, df};
          // scale field holds the right shift amount for the mantissa
          if (!deb[11] && deb != 12'd0) begin
            scale_nxt = 7'd29;
            word_nxt  = 32'(deb[7:0] - 8'd1) << 23;
          end else if ((12'd30 - deb) > 12'd54 && (deb[11] || deb == 12'd0)) begin
            path_nxt = PATH_PASS;
            word_nxt = {raw[63], 31'd0};
          end else begin
            scale_nxt = 7'(12'd30 - deb);
            word_nxt  = 32'd0;
          end
        end
      end
      default: begin
        path_nxt = PATH_ZERO;
      end
    endcase
  end

  path_t       path1_r, path2_r, path3_r;
  logic        sign1_r, sign2_r, sign3_r;
  logic [63:0] mag1_r, mag2_r;
  logic [6:0]  scale1_r, scale2_r;
  logic [31:0] word1_r, word2_r, word3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_if.valid;
    end
    if (adv1) begin
      path1_r  <= path_nxt;
      sign1_r  <= sign_nxt;
      mag1_r   <= mag_nxt;
      scale1_r <= scale_nxt;
      word1_r  <= word_nxt;
    end
  end

  // ---------- stage 2: leading one ----------
  logic [5:0] pos_w;
  logic [5:0] pos2_r;
  pcmf_lzc64 u_lzc (.val(mag1_r), .pos(pos_w));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
    if (adv2) begin
      path2_r  <= path1_r;
      sign2_r  <= sign1_r;
      mag2_r   <= mag1_r;
      scale2_r <= scale1_r;
      word2_r  <= word1_r;
      pos2_r   <= pos_w;
    end
  end

  // ---------- stage 3: shift, keep guard and sticky ----------
  logic [6:0]  sh;
  logic        right;
  logic [63:0] q_w;
  logic [63:0] lost_mask;
  logic        half_w, stk_w;
  logic [63:0] q3_r;
  logic        half3_r, stk3_r, zero3_r;
  logic [7:0]  bexp_w;
  logic [7:0]  bexp3_r;

  always_comb begin
    if (path2_r == PATH_F64) begin
      sh    = scale2_r;
      right = 1'b1;
    end else begin
      right = (pos2_r > 6'd23);
      sh    = right ? 7'(pos2_r - 6'd23) : 7'(6'd23 - pos2_r);
    end
    q_w       = right ? (mag2_r >> sh) : (mag2_r << sh);
    lost_mask = (64'd1 << sh) - 64'd1;
    half_w    = right && (sh != 7'd0) && mag2_r[6'(sh - 7'd1)];
    stk_w     = right && (sh > 7'd1) && |(mag2_r & (lost_mask >> 1));
    bexp_w    = 8'(8'd126 + 8'(pos2_r) - 8'(scale2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
    if (adv3) begin
      path3_r <= path2_r;
      sign3_r <= sign2_r;
      word3_r <= word2_r;
      q3_r    <= q_w;
      half3_r <= half_w;
      stk3_r  <= stk_w;
      zero3_r <= (mag2_r == 64'd0);
      bexp3_r <= bexp_w;
    end
  end

  // ---------- stage 4: round and pack ----------
  logic [31:0] qr;
  logic [31:0] res_w;
  logic [31:0] res4_r;

  always_comb begin
    qr = q3_r[31:0] + 32'(half3_r && (stk3_r || q3_r[0]));
    case (path3_r)
      PATH_INT:  res_w = zero3_r ? 32'd0 : ({sign3_r, 31'd0} + ({24'd0, bexp3_r} << 23) + qr);
      PATH_F64:  res_w = {sign3_r, 31'd0} | (word3_r + qr);
      PATH_PASS: res_w = word3_r;
      default:   res_w = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv4) begin
      v4_r <= v3_r;
    end
    if (adv4) begin
      res4_r <= res_w;
    end
  end

  assign out_if.valid = v4_r;
  assign out_if.data  = res4_r;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_if.ready |=> v4_r && $stable(res4_r))
    else $error("output transaction changed while stalled");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.ready && v1_r && v2_r && v3_r && v4_r |-> !in_if.ready)
    else $error("full pipeline accepted a transaction");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v1_r)
    else $error("accepted transaction lost in stage 1");
`endif
endmodule

>>> hw/rtl/pcmf_lzc64.sv
`timescale 1ns / 1ps
// Leading-one position of a 64-bit word as a two-level search over 8 bytes.
module pcmf_lzc64 (
  input  logic [63:0] val,
  output logic [5:0]  pos
);
  logic [7:0] nz;
  logic [2:0] byte_sel;
  logic [7:0] sel_byte;
  logic [2:0] bit_sel;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nz[i] = |val[8*i +: 8];
    end
    byte_sel = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (nz[i]) begin
        byte_sel = 3'(i);
      end
    end
    sel_byte = val[{byte_sel, 3'b000} +: 8];
    bit_sel = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (sel_byte[i]) begin
        bit_sel = 3'(i);
      end
    end
    pos = {byte_sel, bit_sel};
  end
endmodule

>>> bench/pcm_float_checker.sv
`timescale 1ns / 1ps
module pcm_float_checker
  import pcmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  pcmf_stream_if  in_if,
  pcmf_stream_if  out_if,
  pcmf_stream_if  cfg_if,
  output int      mismatches,
  output int      outstanding,
  output int      converted
);

  logic [2:0]  cur_fmt;
  logic [31:0] float_due_q[$];

  // shift right by sh (1..63), round to nearest, ties to even
  function automatic logic [63:0] round_shift(logic [63:0] m, int sh);
    logic [63:0] q, rem, half;
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // (+/-) mag * 2^-scale; a rounding carry bumps the exponent through the add
  function automatic logic [31:0] scaled_int(logic sgn, logic [63:0] mag, int scale);
    int          msb;
    logic [63:0] mant;
    logic [31:0] bexp;
    if (mag == 64'd0) return 32'd0;
    msb = 63;
    while (!mag[msb]) msb--;
    if (msb > 23) mant = round_shift(mag, msb - 23);
    else          mant = mag << (23 - msb);
    bexp = 32'(127 + msb - scale - 1);
    return ({sgn, 31'd0}) + (bexp << 23) + mant[31:0];
  endfunction

  function automatic logic [31:0] narrow_f64(logic [63:0] d);
    logic [31:0] s;
    logic [10:0] e;
    logic [52:0] m;
    logic [63:0] rs;
    int          eb;
    s = {d[63], 31'd0};
    e = d[62:52];
    if (e == 11'h7FF) begin
      if (d[51:0] == 52'd0) return s | F32_INF;
      return s | F32_QNAN | 32'(d[51:29]);
    end
    if (e == 11'd0) return s;
    m  = {1'b1, d[51:0]};
    eb = int'(e) - 1023 + 127;
    if (eb >= 255) return s | F32_INF;
    if (eb >= 1) begin
      rs = round_shift(64'(m), 29);
      return s | ((32'(eb - 1) << 23) + rs[31:0]);
    end
    if (30 - eb > 54) return s;
    rs = round_shift(64'(m), 30 - eb);
    return s | rs[31:0];
  endfunction

  function automatic logic [31:0] convert(logic [2:0] fmt, logic [63:0] raw);
    case (fmt)
      FMT_U8:  return raw[7] ? scaled_int(1'b0, 64'(raw[7:0]) - 64'd128, 7)
                             : scaled_int(1'b1, 64'd128 - 64'(raw[7:0]), 7);
      FMT_S16: return raw[15] ? scaled_int(1'b1, 64'h10000 - 64'(raw[15:0]), 15)
                              : scaled_int(1'b0, 64'(raw[15:0]), 15);
      FMT_S32: return raw[31] ? scaled_int(1'b1, 64'h1_0000_0000 - 64'(raw[31:0]), 31)
                              : scaled_int(1'b0, 64'(raw[31:0]), 31);
      FMT_S64: return raw[63] ? scaled_int(1'b1, ~raw + 64'd1, 63)
                              : scaled_int(1'b0, raw, 63);
      FMT_F32: return raw[31:0];
      FMT_F64: return narrow_f64(raw);
      default: return 32'd0;
    endcase
  endfunction

  assign outstanding = float_due_q.size();

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      cur_fmt <= FMT_U8;
      float_due_q.delete();
      mismatches <= 0;
      converted <= 0;
    end else begin
      if (in_if.valid && in_if.ready) float_due_q.push_back(convert(cur_fmt, in_if.data));
      if (cfg_if.valid && cfg_if.ready) cur_fmt <= cfg_if.data[2:0];
      if (out_if.valid && out_if.ready) begin
        converted <= converted + 1;
        if (float_due_q.size() == 0) begin
          $error("float_bits: unexpected transaction, actual %h", out_if.data);
          mismatches <= mismatches + 1;
        end else begin
          want = float_due_q.pop_front();
          if (out_if.data[31:0] !== want) begin
            $error("float_bits: expected %h, actual %h", want, out_if.data[31:0]);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/pcm_sample_to_float32_tb.sv
`timescale 1ns / 1ps
module pcm_sample_to_float32_tb;
  import pcmf_pkg::*;

  localparam logic [2:0] FMT_RSVD6 = 3'd6;
  localparam logic [2:0] FMT_RSVD7 = 3'd7;
  localparam int         CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   mismatches, outstanding, converted;
  int   sent = 0;
  bit   hold_off = 1'b0;

  pcmf_stream_if #(.W(64)) in_if ();
  pcmf_stream_if #(.W(32)) out_if ();
  pcmf_stream_if #(.W(3))  cfg_if ();

  pcm_sample_to_float32 u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  pcm_float_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .mismatches(mismatches), .outstanding(outstanding), .converted(converted)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** pcm_sample_to_float32: FAILED **");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // receiver: random stall per transaction, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      out_if.ready = 1'b0;
      repeat (n) @(negedge clk);
      out_if.ready = 1'b1;
      forever begin
        #1;
        if (out_if.valid) break;
        @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(logic [63:0] raw, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = raw;
    forever begin
      #1;
      if (in_if.ready) break;
      @(negedge clk);
    end
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_format(logic [2:0] fmt);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.data = fmt;
    forever begin
      #1;
      if (cfg_if.ready) break;
      @(negedge clk);
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [63:0] rand_sample(logic [2:0] fmt);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (fmt)
      FMT_S16, FMT_S32, FMT_S64, FMT_U8:
        // small magnitudes too, so short values and the rounding boundary both show up
        if ($urandom_range(0, 3) == 0) r = r >> $urandom_range(0, 63);
      FMT_F64: begin
        case ($urandom_range(0, 9))
          0: r[62:52] = 11'h7FF;
          1: r[62:52] = 11'd0;
          2: r[62:52] = 11'(1023 - 150 + $urandom_range(0, 30));
          3: r[51:0] = {23'($urandom), 29'h1000_0000};
          default: r[62:52] = 11'(1023 - 140 + $urandom_range(0, 280));
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    logic [2:0] fmts[8];
    fmts = '{FMT_U8, FMT_S16, FMT_S32, FMT_S64, FMT_F32, FMT_F64, FMT_RSVD6, FMT_RSVD7};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset format u8 first
    send_sample(64'h0, 0);
    send_sample(64'hFFFF_FFFF_FFFF_FF80, 0);
    send_sample(64'hFF, 0);
    set_format(FMT_S16);
    send_sample(64'h8000, 0);
    send_sample(64'h7FFF, 0);
    set_format(FMT_S32);
    send_sample(64'h8000_0000, 0);
    send_sample(64'h7FFF_FFFF, 0);
    send_sample(64'h0100_0003, 0);
    set_format(FMT_S64);
    send_sample(64'h8000_0000_0000_0000, 0);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 0);
    send_sample(64'h0, 0);
    set_format(FMT_F32);
    send_sample(64'hFFFF_FFFF_7F80_0001, 0);
    set_format(FMT_F64);
    send_sample(64'h7FF0_0000_0000_0000, 0);
    send_sample(64'hFFF0_0000_0000_0001, 0);
    send_sample(64'h7FF8_0000_2000_0000, 0);
    send_sample(64'h47F0_0000_0000_0000, 0);
    send_sample(64'h8000_0000_0000_0001, 0);
    send_sample(64'h3690_0000_0000_0000, 0);
    send_sample(64'h36A0_0000_0000_0001, 0);
    send_sample(64'h3FF0_0000_1000_0000, 0);
    send_sample(64'h3FF0_0000_3000_0000, 0);
    set_format(FMT_RSVD7);
    send_sample(64'h1234_5678_9ABC_DEF0, 0);

    // random phases through every format and both reserved codes, then six on random formats
    for (int ph = 0; ph < 14; ph++) begin
      logic [2:0] fmt;
      int n;
      fmt = (ph < 8) ? fmts[ph] : fmts[$urandom_range(0, 5)];
      n = (fmt > FMT_F64) ? 20 : 160;
      set_format(fmt);
      if (ph == 2) hold_off = 1'b1;
      for (int k = 0; k < n; k++) send_sample(rand_sample(fmt), (k % 50) < 10);
    end

    drain();
    repeat (20) @(negedge clk);
    $display("%0d samples sent over all six formats and both reserved codes, %0d checked",
             sent, converted);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** pcm_sample_to_float32: PASSED **");
    end else begin
      $display("** pcm_sample_to_float32: FAILED **");
    end
    $finish;
  end

endmodule
